[rtl/core/hmmd_pkg.sv]
package hmmd_pkg;

    localparam int WORK_RAM_BYTES = 8192;
    localparam int SMALL_BYTES    = 512;
    localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);
    localparam int SMALL_AW       = $clog2(SMALL_BYTES);

    localparam logic [1:0] ACT_READ_BYTE  = 2'd0;
    localparam logic [1:0] ACT_WRITE_BYTE = 2'd1;
    localparam logic [1:0] ACT_READ_WORD  = 2'd2;
    localparam logic [1:0] ACT_WRITE_WORD = 2'd3;

    localparam logic [3:0] TGT_WORK = 4'd0;
    localparam logic [3:0] TGT_ATTR = 4'd1;
    localparam logic [3:0] TGT_HIGH = 4'd2;
    localparam logic [3:0] TGT_IO   = 4'd3;
    localparam logic [3:0] TGT_CART = 4'd4;
    localparam logic [3:0] TGT_VMEM = 4'd5;
    localparam logic [3:0] TGT_VREG = 4'd6;
    localparam logic [3:0] TGT_INT  = 4'd7;
    localparam logic [3:0] TGT_NONE = 4'd8;

    localparam logic [15:0] VMEM_BASE  = 16'h8000;
    localparam logic [15:0] XRAM_BASE  = 16'hA000;
    localparam logic [15:0] WRAM_BASE  = 16'hC000;
    localparam logic [15:0] ECHO_BASE  = 16'hE000;
    localparam logic [15:0] OAM_BASE   = 16'hFE00;
    localparam logic [15:0] UNUSE_BASE = 16'hFEA0;
    localparam logic [15:0] IO_BASE    = 16'hFF00;
    localparam logic [15:0] HRAM_BASE  = 16'hFF80;
    localparam logic [15:0] IE_ADDR    = 16'hFFFF;
    localparam logic [15:0] IF_ADDR    = 16'hFF0F;
    localparam logic [15:0] VREG_FIRST = 16'hFF40;
    localparam logic [15:0] VREG_LAST  = 16'hFF4B;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] bus_address;
        logic [15:0] store_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  target;
        logic [15:0] target_address;
        logic [7:0]  read_data;
        logic [7:0]  forward_data;
        logic        success;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [3:0]          target;
        logic [15:0]         target_address;
        logic                fwd;
        logic                wram_sel;
        logic                small_sel;
        logic [WRAM_AW-1:0]  wram_idx;
        logic [SMALL_AW-1:0] small_idx;
    } dec_t;

endpackage

[rtl/core/hmmd_decode.sv]
module hmmd_decode
    import hmmd_pkg::*;
(
    input  logic [15:0] addr,
    input  logic        is_write,
    output dec_t        dec
);

    always_comb begin
        dec                = '0;
        dec.target         = TGT_NONE;
        dec.wram_idx       = addr[WRAM_AW-1:0];
        dec.small_idx      = addr[SMALL_AW-1:0];
        if (addr < VMEM_BASE || (addr >= XRAM_BASE && addr < WRAM_BASE)) begin
            dec.target         = TGT_CART;
            dec.target_address = addr;
            dec.fwd            = 1'b1;
        end else if (addr < XRAM_BASE) begin
            dec.target         = TGT_VMEM;
            dec.target_address = addr - VMEM_BASE;
            dec.fwd            = 1'b1;
        end else if (addr < OAM_BASE) begin
            // work RAM and its echo share the low address bits
            dec.target   = TGT_WORK;
            dec.wram_sel = 1'b1;
        end else if (addr < UNUSE_BASE) begin
            dec.target    = TGT_ATTR;
            dec.small_sel = 1'b1;
        end else if (addr < IO_BASE) begin
            dec.target = TGT_NONE;
        end else if (addr < HRAM_BASE) begin
            if (addr == IF_ADDR) begin
                dec.target         = TGT_INT;
                dec.target_address = addr;
                dec.fwd            = 1'b1;
            end else if (addr inside {[VREG_FIRST:VREG_LAST]}) begin
                dec.target         = TGT_VREG;
                dec.target_address = addr;
                dec.fwd            = 1'b1;
            end else if (is_write) begin
                dec.target    = TGT_IO;
                dec.small_sel = 1'b1;
            end
        end else if (addr < IE_ADDR) begin
            dec.target    = TGT_HIGH;
            dec.small_sel = 1'b1;
        end else begin
            dec.target         = TGT_INT;
            dec.target_address = addr;
            dec.fwd            = 1'b1;
        end
    end

endmodule

[rtl/core/handheld_memory_map_decoder_top.sv]
// Pipeline: each byte is decoded and registered into p1 on issue, then moved into the
// output register; a word's high byte is issued after its low byte as a separate result.
// Throughput: one byte result per cycle unless m_ready holds the output; a word gives
// two byte results, set by the single port of each store and the issue of one byte per cycle.
// Reset: synchronous active-low; afterwards a clearing pass zeroes the work RAM and
// the small store, with s_ready low until it ends.
module handheld_memory_map_decoder_top
    import hmmd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // small store: attribute RAM, I/O scratch and high RAM at address bits 8:0
    logic [7:0] wram_mem  [WORK_RAM_BYTES];
    logic [7:0] small_mem [SMALL_BYTES];

    logic [WRAM_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic               clr_done_reg, clr_done_next;

    logic        hi_pend_reg, hi_pend_next;
    logic [15:0] hi_addr_reg;
    logic [7:0]  hi_data_reg;
    logic        hi_write_reg;

    logic        p1_valid_reg, p1_valid_next;
    logic [3:0]  p1_target_reg;
    logic [15:0] p1_taddr_reg;
    logic [7:0]  p1_fdata_reg;
    logic        p1_ok_reg;
    logic        p1_last_reg;
    logic        p1_rwram_reg;
    logic        p1_rsmall_reg;
    logic [7:0]  wram_rd_reg;
    logic [7:0]  small_rd_reg;

    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg;

    logic        out_free, p1_free, issue, s_xfer, in_write, in_word;
    logic [15:0] b_addr;
    logic [7:0]  b_data;
    logic        b_write, b_last;
    dec_t        dec;
    out_item_t   p1_item;

    assign in_write = (s_data.action == ACT_WRITE_BYTE) || (s_data.action == ACT_WRITE_WORD);
    assign in_word  = (s_data.action == ACT_READ_WORD) || (s_data.action == ACT_WRITE_WORD);

    assign out_free = !m_valid_reg || m_ready;
    assign p1_free  = !p1_valid_reg || out_free;
    assign s_ready  = clr_done_reg && !hi_pend_reg && p1_free;
    assign s_xfer   = s_valid && s_ready;
    assign issue    = clr_done_reg && p1_free && (hi_pend_reg || s_valid);

    always_comb begin
        if (hi_pend_reg) begin
            b_addr  = hi_addr_reg;
            b_data  = hi_data_reg;
            b_write = hi_write_reg;
            b_last  = 1'b1;
        end else begin
            b_addr  = s_data.bus_address;
            b_data  = s_data.store_value[7:0];
            b_write = in_write;
            b_last  = !in_word;
        end
    end

    hmmd_decode u_decode (
        .addr     (b_addr),
        .is_write (b_write),
        .dec      (dec)
    );

    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        clr_done_next = clr_done_reg;
        if (!clr_done_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (&clr_cnt_reg) begin
                clr_done_next = 1'b1;
            end
        end
        hi_pend_next = hi_pend_reg;
        if (issue && hi_pend_reg) begin
            hi_pend_next = 1'b0;
        end else if (s_xfer && in_word) begin
            hi_pend_next = 1'b1;
        end
        p1_valid_next = p1_valid_reg;
        if (issue) begin
            p1_valid_next = 1'b1;
        end else if (out_free) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = p1_valid_reg;
        end
    end

    always_comb begin
        p1_item                = '0;
        p1_item.target         = p1_target_reg;
        p1_item.target_address = p1_taddr_reg;
        p1_item.forward_data   = p1_fdata_reg;
        p1_item.success        = p1_ok_reg;
        p1_item.last           = p1_last_reg;
        if (p1_rwram_reg) begin
            p1_item.read_data = wram_rd_reg;
        end else if (p1_rsmall_reg) begin
            p1_item.read_data = small_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
            hi_pend_reg  <= 1'b0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_done_reg <= clr_done_next;
            hi_pend_reg  <= hi_pend_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            hi_addr_reg  <= s_data.bus_address + 16'd1;
            hi_data_reg  <= s_data.store_value[15:8];
            hi_write_reg <= in_write;
        end
        if (issue) begin
            p1_target_reg <= dec.target;
            p1_taddr_reg  <= dec.target_address;
            p1_fdata_reg  <= (b_write && dec.fwd) ? b_data : 8'd0;
            p1_ok_reg     <= b_write && (dec.fwd || dec.wram_sel || dec.small_sel);
            p1_last_reg   <= b_last;
            p1_rwram_reg  <= !b_write && dec.wram_sel;
            p1_rsmall_reg <= !b_write && dec.small_sel;
        end
        if (out_free && p1_valid_reg) begin
            m_data_reg <= p1_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!clr_done_reg) begin
            wram_mem[clr_cnt_reg] <= 8'd0;
        end else if (issue && b_write && dec.wram_sel) begin
            wram_mem[dec.wram_idx] <= b_data;
        end
        if (issue) begin
            wram_rd_reg <= wram_mem[dec.wram_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!clr_done_reg) begin
            small_mem[clr_cnt_reg[SMALL_AW-1:0]] <= 8'd0;
        end else if (issue && b_write && dec.small_sel) begin
            small_mem[dec.small_idx] <= b_data;
        end
        if (issue) begin
            small_rd_reg <= small_mem[dec.small_idx];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[test/tb_handheld_memory_map_decoder_top.sv]
`timescale 1ns / 1ps

module tb_handheld_memory_map_decoder_top;
    import hmmd_pkg::*;

    localparam int OAM_BYTES   = 160;
    localparam int IO_BYTES    = 128;
    localparam int HRAM_BYTES  = 127;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_GAP     = 30;
    localparam int SHOWN_ERRS  = 10;

    class decode_scoreboard;
        logic [7:0] work_mem [WORK_RAM_BYTES];
        logic [7:0] oam_mem  [OAM_BYTES];
        logic [7:0] io_mem   [IO_BYTES];
        logic [7:0] hram_mem [HRAM_BYTES];
        out_item_t  expected_bytes [$];
        int         mismatches;

        function new();
            foreach (work_mem[i]) work_mem[i] = 8'h00;
            foreach (oam_mem[i]) oam_mem[i] = 8'h00;
            foreach (io_mem[i]) io_mem[i] = 8'h00;
            foreach (hram_mem[i]) hram_mem[i] = 8'h00;
            mismatches = 0;
        endfunction

        function out_item_t decode_byte(logic [15:0] addr, bit wr, logic [7:0] data,
                                        bit is_last);
            out_item_t r;
            bit        fwd;
            int        idx;
            r        = '0;
            r.target = TGT_NONE;
            r.last   = is_last;
            fwd      = 1'b0;
            if (addr < VMEM_BASE || (addr >= XRAM_BASE && addr < WRAM_BASE)) begin
                r.target = TGT_CART;
                r.target_address = addr;
                fwd = 1'b1;
            end else if (addr < XRAM_BASE) begin
                r.target = TGT_VMEM;
                r.target_address = addr - VMEM_BASE;
                fwd = 1'b1;
            end else if (addr < OAM_BASE) begin
                r.target = TGT_WORK;
                idx = (addr < ECHO_BASE) ? int'(addr - WRAM_BASE) : int'(addr - ECHO_BASE);
                if (wr) begin
                    work_mem[idx] = data;
                    r.success = 1'b1;
                end else begin
                    r.read_data = work_mem[idx];
                end
            end else if (addr < UNUSE_BASE) begin
                r.target = TGT_ATTR;
                idx = int'(addr - OAM_BASE);
                if (wr) begin
                    oam_mem[idx] = data;
                    r.success = 1'b1;
                end else begin
                    r.read_data = oam_mem[idx];
                end
            end else if (addr < IO_BASE) begin
                r.target = TGT_NONE;
            end else if (addr < HRAM_BASE) begin
                if (addr == IF_ADDR) begin
                    r.target = TGT_INT;
                    r.target_address = addr;
                    fwd = 1'b1;
                end else if (addr >= VREG_FIRST && addr <= VREG_LAST) begin
                    r.target = TGT_VREG;
                    r.target_address = addr;
                    fwd = 1'b1;
                end else if (wr) begin
                    // write-only scratch, never read back
                    r.target = TGT_IO;
                    io_mem[int'(addr - IO_BASE)] = data;
                    r.success = 1'b1;
                end
            end else if (addr < IE_ADDR) begin
                r.target = TGT_HIGH;
                idx = int'(addr - HRAM_BASE);
                if (wr) begin
                    hram_mem[idx] = data;
                    r.success = 1'b1;
                end else begin
                    r.read_data = hram_mem[idx];
                end
            end else begin
                r.target = TGT_INT;
                r.target_address = addr;
                fwd = 1'b1;
            end
            if (fwd && wr) begin
                r.forward_data = data;
                r.success = 1'b1;
            end
            return r;
        endfunction

        function void note_input(in_item_t it);
            bit wr;
            wr = it.action[0];
            if (it.action == ACT_READ_BYTE || it.action == ACT_WRITE_BYTE) begin
                expected_bytes.push_back(decode_byte(it.bus_address, wr,
                                                     it.store_value[7:0], 1'b1));
            end else begin
                expected_bytes.push_back(decode_byte(it.bus_address, wr,
                                                     it.store_value[7:0], 1'b0));
                expected_bytes.push_back(decode_byte(it.bus_address + 16'd1, wr,
                                                     it.store_value[15:8], 1'b1));
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRS)
                    $display("unexpected result transfer: %p", got);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.target !== want.target || got.target_address !== want.target_address ||
                got.read_data !== want.read_data || got.forward_data !== want.forward_data ||
                got.success !== want.success || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRS)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    decode_scoreboard sb = new();
    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int long_hold_cycles  = 0;
    int cycle_count       = 0;

    handheld_memory_map_decoder_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_handheld_memory_map_decoder_top NOT OK");
        $finish;
    end

    function automatic int idle_gap(int pct);
        int n;
        n = 0;
        while (n < MAX_GAP && $urandom_range(99) < pct) n++;
        return n;
    endfunction

    // result side: random backpressure plus an optional long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready)
                sb.check_result(m_data);
            if (long_hold_cycles > 0) begin
                long_hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input in_item_t it);
        int gap;
        gap = idle_gap(send_idle_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
    endtask

    task automatic send_access(input logic [1:0] act, input logic [15:0] addr,
                               input logic [15:0] value);
        in_item_t it;
        it.action      = act;
        it.bus_address = addr;
        it.store_value = value;
        send_item(it);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_address();
        logic [15:0] a;
        case ($urandom_range(11))
            0:       a = 16'($urandom_range(16'hFFFF));
            1:       a = $urandom_range(1) ? 16'($urandom_range(16'h7FFF))
                                           : 16'($urandom_range(16'hA000, 16'hBFFF));
            2:       a = 16'($urandom_range(16'h8000, 16'h9FFF));
            3, 4:    a = (($urandom_range(1) ? WRAM_BASE : ECHO_BASE)
                          + 16'($urandom_range(63)));
            5:       a = 16'($urandom_range(16'hC000, 16'hFDFF));
            6:       a = 16'($urandom_range(16'hFE00, 16'hFE9F));
            7:       a = 16'($urandom_range(16'hFEA0, 16'hFEFF));
            8:       a = 16'($urandom_range(16'hFF00, 16'hFF7F));
            9:       a = 16'($urandom_range(16'hFF80, 16'hFFFF));
            default: begin
                case ($urandom_range(7))
                    0: a = 16'h7FFF;
                    1: a = 16'hDFFF;
                    2: a = 16'hFDFF;
                    3: a = 16'hFE9F;
                    4: a = 16'hFEFF;
                    5: a = 16'hFF0F;
                    6: a = 16'hFF3F + 16'($urandom_range(13));
                    default: a = 16'hFFFF;
                endcase
            end
        endcase
        return a;
    endfunction

    task automatic send_random(input int count);
        repeat (count)
            send_access(2'($urandom_range(3)), pick_address(),
                        16'($urandom_range(16'hFFFF)));
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 66;

        send_access(ACT_READ_BYTE,  16'h0000, 16'h0000);
        send_access(ACT_WRITE_BYTE, 16'hFFFF, 16'hFFFF);
        send_access(ACT_WRITE_BYTE, 16'hC000, 16'h00A5);
        send_access(ACT_READ_BYTE,  16'hE000, 16'h0000);
        send_access(ACT_WRITE_WORD, 16'hFDFF, 16'h5A3C);
        send_access(ACT_READ_WORD,  16'hDFFF, 16'hFFFF);
        send_access(ACT_WRITE_BYTE, 16'hFE9F, 16'h0077);
        send_access(ACT_READ_WORD,  16'hFE9F, 16'h0000);
        send_access(ACT_WRITE_BYTE, 16'hFEA0, 16'h0011);
        send_access(ACT_READ_BYTE,  16'hFEFF, 16'h0000);
        send_access(ACT_WRITE_WORD, 16'hFE9F, 16'h1234);
        send_access(ACT_WRITE_WORD, 16'hFEFF, 16'hBEEF);
        send_access(ACT_READ_BYTE,  16'hFF00, 16'h0000);
        send_access(ACT_WRITE_BYTE, 16'hFF0F, 16'h001F);
        send_access(ACT_READ_BYTE,  16'hFF0F, 16'h0000);
        send_access(ACT_WRITE_WORD, 16'hFF3F, 16'h9181);
        send_access(ACT_READ_WORD,  16'hFF4B, 16'h0000);
        send_access(ACT_WRITE_WORD, 16'hFF7F, 16'h4422);
        send_access(ACT_READ_WORD,  16'hFFFE, 16'h0000);
        send_access(ACT_WRITE_WORD, 16'hFFFF, 16'hCAFE);
        send_access(ACT_READ_WORD,  16'hFFFF, 16'h0000);
        send_access(ACT_WRITE_WORD, 16'h7FFF, 16'h0102);
        send_access(ACT_READ_WORD,  16'h9FFF, 16'h0000);
        send_access(ACT_READ_BYTE,  16'hBFFF, 16'h0000);
        send_access(ACT_READ_BYTE,  16'hC000, 16'h0000);

        send_random(600);
        drain_results();

        // stall the result side long enough to back up the input
        send_idle_pct = 0;
        long_hold_cycles = 300;
        send_random(40);
        drain_results();

        send_idle_pct = 66;
        recv_idle_pct = 12;
        send_random(600);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(610);
        drain_results();
        repeat (10) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_handheld_memory_map_decoder_top OK");
        end else begin
            $display("tb_handheld_memory_map_decoder_top NOT OK");
        end
        $finish;
    end

endmodule
